// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that holds on every clock edge outside reset
`define DAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that holds on every clock edge while the result beat is valid
`define DAS_ASSERT_OUT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (m_valid |-> (prop))) else $error(msg);

`endif

// ===== rtl/das_pkg.sv =====
package das_pkg;

    localparam int unsigned CFG_W     = 15;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned VAL_W     = 16;
    localparam int unsigned CMP_W     = 18;
    localparam int unsigned PHASE_W   = 3;

    localparam logic signed [CMP_W-1:0] HEADING_TOL  = 18'sd123;
    localparam logic signed [CMP_W-1:0] QUARTER_TURN = 18'sd6434;

    typedef enum logic [PHASE_W-1:0] {
        PH_TURN     = 3'd0,
        PH_CENTER   = 3'd1,
        PH_ALIGN    = 3'd2,
        PH_APPROACH = 3'd3,
        PH_DONE     = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SLOW_LINEAR  = 3'd0,
        REG_FAST_LINEAR  = 3'd1,
        REG_SLOW_TURN    = 3'd2,
        REG_FAST_TURN    = 3'd3,
        REG_DOCK_DIST    = 3'd4,
        REG_CENTER_DIST  = 3'd5,
        REG_LINEAR_BAND  = 3'd6,
        REG_ANGULAR_BAND = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] slow_linear_speed;
        logic [CFG_W-1:0] fast_linear_speed;
        logic [CFG_W-1:0] slow_turn_rate;
        logic [CFG_W-1:0] fast_turn_rate;
        logic [CFG_W-1:0] dock_distance;
        logic [CFG_W-1:0] center_distance;
        logic [CFG_W-1:0] linear_slow_band;
        logic [CFG_W-1:0] angular_slow_band;
    } cfg_t;

    typedef struct packed {
        phase_t                   phase;
        logic signed [VAL_W-1:0]  linear;
        logic signed [VAL_W-1:0]  angular;
    } seq_state_t;

endpackage

// ===== rtl/docking_approach_sequencer_unit.sv =====
// channel  | handshake             | payload
// s_       | s_valid / s_ready     | s_pose_x, s_pose_yaw, s_dock_on_left
// m_       | m_valid / m_ready     | m_linear_velocity, m_angular_velocity, m_phase, m_docked
// cfg_     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one pose beat per cycle sustained while the result is not stalled; an accepted beat passes
// through the input register, phase and velocity logic, then the state/result register
// the phase and held velocities double as the result register, so a beat's result is the
// state after it and the next beat is evaluated against it
// reset clears phase and held velocities to zero and loads register defaults
// a stalled result holds both stages; the input side still takes one beat into a free slot
`include "assert_macros.svh"

module docking_approach_sequencer_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [das_pkg::VAL_W-1:0]     s_pose_x,
    input  logic signed [das_pkg::VAL_W-1:0]     s_pose_yaw,
    input  logic                                 s_dock_on_left,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [das_pkg::VAL_W-1:0]     m_linear_velocity,
    output logic signed [das_pkg::VAL_W-1:0]     m_angular_velocity,
    output logic [das_pkg::PHASE_W-1:0]          m_phase,
    output logic                                 m_docked,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [das_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [das_pkg::CFG_W-1:0]            cfg_data
);

    das_pkg::cfg_t                     cfg;
    das_pkg::seq_state_t               state_reg, state_next;
    logic                              in_valid_reg, out_valid_reg;
    logic signed [das_pkg::VAL_W-1:0]  x_reg, yaw_reg;
    logic                              left_reg;
    logic                              advance;

    das_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    das_core u_core (
        .cfg          (cfg),
        .cur          (state_reg),
        .pose_x       (x_reg),
        .pose_yaw     (yaw_reg),
        .dock_on_left (left_reg),
        .nxt          (state_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: das_pkg::PH_TURN, linear: '0, angular: '0};
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            x_reg    <= s_pose_x;
            yaw_reg  <= s_pose_yaw;
            left_reg <= s_dock_on_left;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_linear_velocity  = state_reg.linear;
    assign m_angular_velocity = state_reg.angular;
    assign m_phase            = state_reg.phase;
    assign m_docked           = (state_reg.phase == das_pkg::PH_DONE);

    `DAS_ASSERT(a_phase_step,
        (state_reg.phase != $past(state_reg.phase)) |->
            (state_reg.phase == das_pkg::PHASE_W'($past(state_reg.phase) + 3'd1)),
        "phase moved other than one step up")
    `DAS_ASSERT(a_hold_stall, (out_valid_reg && !m_ready) |=> $stable(state_reg),
        "state changed while result stalled")
    `DAS_ASSERT_OUT(a_done_zero,
        (m_phase != das_pkg::PH_DONE) ||
            (m_linear_velocity == 16'sd0 && m_angular_velocity == 16'sd0),
        "nonzero velocity after docking")
    `DAS_ASSERT_OUT(a_turn_no_drive,
        (m_phase != das_pkg::PH_TURN) || (m_linear_velocity == 16'sd0),
        "linear motion during turn phase")

endmodule

// ===== rtl/das_cfg.sv =====
module das_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [das_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [das_pkg::CFG_W-1:0]      cfg_data,
    output das_pkg::cfg_t                  cfg
);

    das_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_linear_speed <= 15'd410;
            cfg_reg.fast_linear_speed <= 15'd1229;
            cfg_reg.slow_turn_rate    <= 15'd410;
            cfg_reg.fast_turn_rate    <= 15'd1229;
            cfg_reg.dock_distance     <= 15'd1229;
            cfg_reg.center_distance   <= 15'd123;
            cfg_reg.linear_slow_band  <= 15'd1229;
            cfg_reg.angular_slow_band <= 15'd1638;
        end else if (cfg_valid) begin
            case (das_pkg::reg_idx_t'(cfg_index))
                das_pkg::REG_SLOW_LINEAR:  cfg_reg.slow_linear_speed <= cfg_data;
                das_pkg::REG_FAST_LINEAR:  cfg_reg.fast_linear_speed <= cfg_data;
                das_pkg::REG_SLOW_TURN:    cfg_reg.slow_turn_rate    <= cfg_data;
                das_pkg::REG_FAST_TURN:    cfg_reg.fast_turn_rate    <= cfg_data;
                das_pkg::REG_DOCK_DIST:    cfg_reg.dock_distance     <= cfg_data;
                das_pkg::REG_CENTER_DIST:  cfg_reg.center_distance   <= cfg_data;
                das_pkg::REG_LINEAR_BAND:  cfg_reg.linear_slow_band  <= cfg_data;
                das_pkg::REG_ANGULAR_BAND: cfg_reg.angular_slow_band <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/das_core.sv =====
module das_core (
    input  das_pkg::cfg_t                      cfg,
    input  das_pkg::seq_state_t                cur,
    input  logic signed [das_pkg::VAL_W-1:0]   pose_x,
    input  logic signed [das_pkg::VAL_W-1:0]   pose_yaw,
    input  logic                               dock_on_left,
    output das_pkg::seq_state_t                nxt
);

    logic signed [das_pkg::CMP_W-1:0] x, nx, yaw, ax, ayaw, e, p;
    logic signed [das_pkg::CMP_W-1:0] tw, tv, cd, dd;
    logic signed [das_pkg::VAL_W-1:0] vmin, vmax, wmin, wmax;

    assign x    = {{2{pose_x[15]}}, pose_x};
    assign yaw  = {{2{pose_yaw[15]}}, pose_yaw};
    assign nx   = -x;
    assign ax   = x[17] ? -x : x;
    assign ayaw = yaw[17] ? -yaw : yaw;
    assign e    = das_pkg::HEADING_TOL;
    assign p    = das_pkg::QUARTER_TURN;
    assign tw   = {3'b000, cfg.angular_slow_band};
    assign tv   = {3'b000, cfg.linear_slow_band};
    assign cd   = {3'b000, cfg.center_distance};
    assign dd   = {3'b000, cfg.dock_distance};
    assign vmin = {1'b0, cfg.slow_linear_speed};
    assign vmax = {1'b0, cfg.fast_linear_speed};
    assign wmin = {1'b0, cfg.slow_turn_rate};
    assign wmax = {1'b0, cfg.fast_turn_rate};

    always_comb begin
        nxt = cur;
        case (cur.phase)
            das_pkg::PH_TURN: begin
                nxt.linear = '0;
                if (dock_on_left) begin
                    if (p - e <= yaw && yaw <= p + e) begin
                        nxt.angular = '0;
                        nxt.phase   = das_pkg::PH_CENTER;
                    end else if (p - tw <= yaw && yaw < p - e) begin
                        nxt.angular = -wmin;
                    end else if (-p <= yaw && yaw < p - tw) begin
                        nxt.angular = -wmax;
                    end else if (p + e <= yaw && yaw < p + tw) begin
                        nxt.angular = wmin;
                    end else begin
                        nxt.angular = wmax;
                    end
                end else begin
                    if (-p - e <= yaw && yaw <= -p + e) begin
                        nxt.angular = '0;
                        nxt.phase   = das_pkg::PH_CENTER;
                    end else if (-p + e <= yaw && yaw < -p + tw) begin
                        nxt.angular = wmin;
                    end else if (-p + tw <= yaw && yaw < p) begin
                        nxt.angular = wmax;
                    end else if (-p - tw <= yaw && yaw < -p - e) begin
                        nxt.angular = -wmin;
                    end else begin
                        nxt.angular = -wmax;
                    end
                end
            end
            das_pkg::PH_CENTER: begin
                if (ax <= cd) begin
                    nxt.linear = '0;
                    nxt.phase  = das_pkg::PH_ALIGN;
                end else if (cd < nx && nx < cd + tv) begin
                    nxt.linear = -vmin;
                end else if (cd < x && x < cd + tv) begin
                    nxt.linear = vmin;
                end else begin
                    nxt.linear = -vmax;
                end
            end
            das_pkg::PH_ALIGN: begin
                if (ayaw <= e) begin
                    nxt.angular = '0;
                    nxt.phase   = das_pkg::PH_APPROACH;
                end else if (e <= yaw && yaw < tw) begin
                    nxt.angular = wmin;
                end else if (-tw <= yaw && yaw < -e) begin
                    nxt.angular = -wmin;
                end else if (tw <= yaw) begin
                    nxt.angular = wmax;
                end else begin
                    nxt.angular = -wmax;
                end
            end
            das_pkg::PH_APPROACH: begin
                if (ax < dd) begin
                    nxt.linear = '0;
                    nxt.phase  = das_pkg::PH_DONE;
                end else if (ax <= dd + tv) begin
                    nxt.linear = -vmin;
                end else begin
                    nxt.linear = -vmax;
                end
            end
            default: begin
                nxt.linear  = '0;
                nxt.angular = '0;
            end
        endcase
    end

endmodule
